>>> hdl/u8sr_pkg.sv
// Shared constants and types of the UTF-8 stream reassembler.
`timescale 1ns / 1ps

package u8sr_pkg;

    // Hold buffer geometry
    localparam int HOLD_DEPTH = 64;
    localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

    // Field widths
    localparam int SYM_W    = 9;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CP_W     = 21;

    // Longest tail that a token end may hold back
    localparam int TAIL_MAX = 3;

    // Command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Outcome of feeding one byte to the character decoder
    typedef enum logic [1:0] {
        DEC_MORE = 2'b00,
        DEC_DONE = 2'b01,
        DEC_BAD  = 2'b10
    } dec_res_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_item;
        logic push_write;
        logic scan_init;
        logic scan_step;
        logic rd_issue;
        logic emit_init;
        logic emit_load;
        logic err_load;
        logic flush_init;
        logic flush_step;
        logic char_load;
        logic rep_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic     item_flush;
        logic     item_ok;
        logic     item_tend;
        logic     full;
        logic     empty;
        logic     at_end;
        dec_res_t dec_res;
        logic     scan_accept;
        logic     emit_last;
        logic     out_free;
        logic     char_byte_last;
        logic     char_final;
        logic     rep_final;
    } dp_stat_t;

endpackage

>>> hdl/u8sr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module u8sr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/u8sr_dp.sv
// Datapath: item latch, hold buffer with pointers, UTF-8 decoder, result register.
`timescale 1ns / 1ps

module u8sr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  u8sr_pkg::dp_cmd_t                 ctl_cmd,
    output u8sr_pkg::dp_stat_t                stat,
    input  logic                              in_cmd,
    input  logic [u8sr_pkg::SYM_W-1:0]        in_symbol,
    input  logic                              in_token_end,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [u8sr_pkg::BYTE_W-1:0]       out_byte,
    output logic                              replacement,
    output logic [u8sr_pkg::STATUS_W-1:0]     status,
    output logic                              run_last
);

    localparam int AW  = u8sr_pkg::HOLD_AW;
    localparam int CW  = u8sr_pkg::CNT_W;
    localparam int BW  = u8sr_pkg::BYTE_W;
    localparam int CPW = u8sr_pkg::CP_W;

    typedef struct packed {
        logic          ok;
        logic [BW-1:0] value;
    } map_t;

    // Inverse byte table of the byte-level alphabet
    function automatic map_t sym_to_byte(input logic [u8sr_pkg::SYM_W-1:0] s);
        map_t m;
        m.ok    = 1'b0;
        m.value = '0;
        if ((s >= 9'd33 && s <= 9'd126) || (s >= 9'd161 && s <= 9'd172) ||
            (s >= 9'd174 && s <= 9'd255))
        begin
            m.ok    = 1'b1;
            m.value = s[BW-1:0];
        end
        else if (s >= 9'd256 && s <= 9'd288)
        begin
            m.ok    = 1'b1;
            m.value = s[BW-1:0];
        end
        else if (s >= 9'd289 && s <= 9'd322)
        begin
            m.ok    = 1'b1;
            m.value = BW'(s - 9'd162);
        end
        else if (s == 9'd323)
        begin
            m.ok    = 1'b1;
            m.value = 8'd173;
        end
        return m;
    endfunction

    // Circular address of a logical buffer index
    function automatic logic [AW-1:0] hold_addr(input logic [AW-1:0] b,
                                                input logic [CW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, b} + {1'b0, idx[AW-1:0]};
        if (sum >= (AW+1)'(u8sr_pkg::HOLD_DEPTH))
        begin
            sum = sum - (AW+1)'(u8sr_pkg::HOLD_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Control registers
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] base_reg, base_next;
    logic          out_vld_reg, out_vld_next;

    // Payload and work registers
    logic                          item_flush_reg, item_flush_next;
    logic                          item_ok_reg, item_ok_next;
    logic                          item_tend_reg, item_tend_next;
    logic [BW-1:0]                 item_byte_reg, item_byte_next;
    logic [CW-1:0]                 pos_reg, pos_next;
    logic [CW-1:0]                 bound_reg, bound_next;
    logic [CW-1:0]                 cs_reg, cs_next;
    logic [1:0]                    dcnt_reg, dcnt_next;
    logic [2:0]                    dneed_reg, dneed_next;
    logic [2:0]                    dlen_reg, dlen_next;
    logic [CPW-1:0]                dcp_reg, dcp_next;
    logic [1:0]                    k_reg, k_next;
    logic [BW-1:0]                 cbuf_reg [4];
    logic [BW-1:0]                 cbuf_next [4];
    logic [BW-1:0]                 ob_reg, ob_next;
    logic                          orep_reg, orep_next;
    logic [u8sr_pkg::STATUS_W-1:0] ost_reg, ost_next;
    logic                          olast_reg, olast_next;

    // Buffer port
    logic [BW-1:0] ram_rdata;

    // Decoder
    u8sr_pkg::dec_res_t dec_res;
    logic [2:0]         dec_need;
    logic [CPW-1:0]     dec_cp;
    logic [CPW-1:0]     cp_shift;
    logic [CPW-1:0]     cp_lo;

    map_t          in_map;
    logic          out_take;
    logic [CW-1:0] char_end;
    logic [CW-1:0] cs_plus1;
    logic          char_byte_last;
    logic          char_final;
    logic          rep_final;
    logic          emit_last;

    u8sr_ram #(
        .WIDTH(u8sr_pkg::BYTE_W),
        .DEPTH(u8sr_pkg::HOLD_DEPTH)
    ) u_hold (
        .clk  (clk),
        .we   (ctl_cmd.push_write),
        .waddr(hold_addr(base_reg, count_reg)),
        .wdata(item_byte_reg),
        .re   (ctl_cmd.rd_issue),
        .raddr(hold_addr(base_reg, pos_reg)),
        .rdata(ram_rdata)
    );

    assign in_map   = sym_to_byte(in_symbol);
    assign out_take = out_vld_reg && !out_stall;

    // One byte of the character decoder
    assign cp_shift = {dcp_reg[CPW-7:0], ram_rdata[5:0]};

    always_comb
    begin
        unique case (dneed_reg)
            3'd2:    cp_lo = 21'h00080;
            3'd3:    cp_lo = 21'h00800;
            default: cp_lo = 21'h10000;
        endcase
    end

    always_comb
    begin
        dec_res  = u8sr_pkg::DEC_BAD;
        dec_need = dneed_reg;
        dec_cp   = cp_shift;
        if (dcnt_reg == 2'd0)
        begin
            dec_cp = {{(CPW-BW){1'b0}}, ram_rdata};
            priority if (ram_rdata[7] == 1'b0)
            begin
                dec_res  = u8sr_pkg::DEC_DONE;
                dec_need = 3'd1;
            end
            else if ((ram_rdata & 8'he0) == 8'hc0)
            begin
                dec_res  = u8sr_pkg::DEC_MORE;
                dec_need = 3'd2;
                dec_cp   = {{(CPW-5){1'b0}}, ram_rdata[4:0]};
            end
            else if ((ram_rdata & 8'hf0) == 8'he0)
            begin
                dec_res  = u8sr_pkg::DEC_MORE;
                dec_need = 3'd3;
                dec_cp   = {{(CPW-4){1'b0}}, ram_rdata[3:0]};
            end
            else if ((ram_rdata & 8'hf8) == 8'hf0)
            begin
                dec_res  = u8sr_pkg::DEC_MORE;
                dec_need = 3'd4;
                dec_cp   = {{(CPW-3){1'b0}}, ram_rdata[2:0]};
            end
            else
            begin
                dec_res = u8sr_pkg::DEC_BAD;
            end
        end
        else
        begin
            priority if (ram_rdata[7:6] != 2'b10)
            begin
                dec_res = u8sr_pkg::DEC_BAD;
            end
            else if ({1'b0, dcnt_reg} + 3'd1 != dneed_reg)
            begin
                dec_res = u8sr_pkg::DEC_MORE;
            end
            else if (cp_shift < cp_lo || cp_shift > 21'h10ffff ||
                     (cp_shift >= 21'h0d800 && cp_shift <= 21'h0dfff))
            begin
                dec_res = u8sr_pkg::DEC_BAD;
            end
            else
            begin
                dec_res = u8sr_pkg::DEC_DONE;
            end
        end
    end

    assign char_end       = cs_reg + {{(CW-3){1'b0}}, dlen_reg};
    assign cs_plus1       = cs_reg + CW'(1);
    assign char_byte_last = ({1'b0, k_reg} == dlen_reg - 3'd1);
    assign char_final     = char_byte_last && (char_end == count_reg);
    assign rep_final      = (cs_plus1 == count_reg);
    assign emit_last      = (pos_reg + CW'(1) == bound_reg);

    always_comb
    begin
        stat.item_flush     = item_flush_reg;
        stat.item_ok        = item_ok_reg;
        stat.item_tend      = item_tend_reg;
        stat.full           = (count_reg == CW'(u8sr_pkg::HOLD_DEPTH));
        stat.empty          = (count_reg == '0);
        stat.at_end         = (pos_reg == count_reg);
        stat.dec_res        = dec_res;
        stat.scan_accept    = (bound_reg == count_reg) ||
                              (bound_reg != '0 &&
                               (count_reg - bound_reg) <= CW'(u8sr_pkg::TAIL_MAX));
        stat.emit_last      = emit_last;
        stat.out_free       = !out_vld_reg || !out_stall;
        stat.char_byte_last = char_byte_last;
        stat.char_final     = char_final;
        stat.rep_final      = rep_final;
    end

    always_comb
    begin
        count_next      = count_reg;
        base_next       = base_reg;
        item_flush_next = item_flush_reg;
        item_ok_next    = item_ok_reg;
        item_tend_next  = item_tend_reg;
        item_byte_next  = item_byte_reg;
        pos_next        = pos_reg;
        bound_next      = bound_reg;
        cs_next         = cs_reg;
        dcnt_next       = dcnt_reg;
        dneed_next      = dneed_reg;
        dlen_next       = dlen_reg;
        dcp_next        = dcp_reg;
        k_next          = k_reg;
        cbuf_next       = cbuf_reg;
        ob_next         = ob_reg;
        orep_next       = orep_reg;
        ost_next        = ost_reg;
        olast_next      = olast_reg;
        out_vld_next    = out_take ? 1'b0 : out_vld_reg;

        // Latch the accepted item
        if (ctl_cmd.take_item)
        begin
            item_flush_next = (in_cmd == u8sr_pkg::CMD_FLUSH);
            item_ok_next    = in_map.ok;
            item_tend_next  = in_token_end;
            item_byte_next  = in_map.value;
        end

        if (ctl_cmd.push_write)
        begin
            count_next = count_reg + CW'(1);
        end

        if (ctl_cmd.scan_init)
        begin
            pos_next   = '0;
            bound_next = '0;
            dcnt_next  = '0;
        end

        if (ctl_cmd.flush_init)
        begin
            pos_next  = '0;
            cs_next   = '0;
            dcnt_next = '0;
            k_next    = '0;
        end

        // Advance the validity scan; bound marks the end of the last good character
        if (ctl_cmd.scan_step)
        begin
            unique case (dec_res)
                u8sr_pkg::DEC_MORE:
                begin
                    dcnt_next  = dcnt_reg + 2'd1;
                    dneed_next = dec_need;
                    dcp_next   = dec_cp;
                    pos_next   = pos_reg + CW'(1);
                end
                u8sr_pkg::DEC_DONE:
                begin
                    dcnt_next  = '0;
                    pos_next   = pos_reg + CW'(1);
                    bound_next = pos_reg + CW'(1);
                end
                default:
                begin
                end
            endcase
        end

        // Collect one character for flush
        if (ctl_cmd.flush_step)
        begin
            unique case (dec_res)
                u8sr_pkg::DEC_MORE:
                begin
                    cbuf_next[dcnt_reg] = ram_rdata;
                    dcnt_next           = dcnt_reg + 2'd1;
                    dneed_next          = dec_need;
                    dcp_next            = dec_cp;
                    pos_next            = pos_reg + CW'(1);
                end
                u8sr_pkg::DEC_DONE:
                begin
                    cbuf_next[dcnt_reg] = ram_rdata;
                    dlen_next           = {1'b0, dcnt_reg} + 3'd1;
                    k_next              = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (ctl_cmd.emit_init)
        begin
            pos_next = '0;
        end

        // Emit the accepted prefix; release it from the buffer on its last byte
        if (ctl_cmd.emit_load)
        begin
            out_vld_next = 1'b1;
            ob_next      = ram_rdata;
            orep_next    = 1'b0;
            ost_next     = u8sr_pkg::STATUS_OK;
            olast_next   = emit_last;
            pos_next     = pos_reg + CW'(1);
            if (emit_last)
            begin
                count_next = count_reg - bound_reg;
                base_next  = (bound_reg == count_reg) ? '0 : hold_addr(base_reg, bound_reg);
            end
        end

        if (ctl_cmd.err_load)
        begin
            out_vld_next = 1'b1;
            ob_next      = '0;
            orep_next    = 1'b0;
            ost_next     = item_ok_reg ? u8sr_pkg::STATUS_OVERFLOW
                                       : u8sr_pkg::STATUS_UNMAPPED;
            olast_next   = 1'b1;
        end

        if (ctl_cmd.char_load)
        begin
            out_vld_next = 1'b1;
            ob_next      = cbuf_reg[k_reg];
            orep_next    = 1'b0;
            ost_next     = u8sr_pkg::STATUS_OK;
            olast_next   = char_final;
            if (char_byte_last)
            begin
                cs_next   = char_end;
                pos_next  = char_end;
                dcnt_next = '0;
                k_next    = '0;
                if (char_final)
                begin
                    count_next = '0;
                    base_next  = '0;
                end
            end
            else
            begin
                k_next = k_reg + 2'd1;
            end
        end

        if (ctl_cmd.rep_load)
        begin
            out_vld_next = 1'b1;
            ob_next      = '0;
            orep_next    = 1'b1;
            ost_next     = u8sr_pkg::STATUS_OK;
            olast_next   = rep_final;
            cs_next      = cs_plus1;
            pos_next     = cs_plus1;
            dcnt_next    = '0;
            if (rep_final)
            begin
                count_next = '0;
                base_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            base_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            base_reg    <= base_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_flush_reg <= item_flush_next;
        item_ok_reg    <= item_ok_next;
        item_tend_reg  <= item_tend_next;
        item_byte_reg  <= item_byte_next;
        pos_reg        <= pos_next;
        bound_reg      <= bound_next;
        cs_reg         <= cs_next;
        dcnt_reg       <= dcnt_next;
        dneed_reg      <= dneed_next;
        dlen_reg       <= dlen_next;
        dcp_reg        <= dcp_next;
        k_reg          <= k_next;
        cbuf_reg       <= cbuf_next;
        ob_reg         <= ob_next;
        orep_reg       <= orep_next;
        ost_reg        <= ost_next;
        olast_reg      <= olast_next;
    end

    assign out_valid   = out_vld_reg;
    assign out_byte    = ob_reg;
    assign replacement = orep_reg;
    assign status      = ost_reg;
    assign run_last    = olast_reg;

endmodule

>>> hdl/u8sr_ctl.sv
// Controller: sequences push, error results, token-end scan and emit, and flush.
`timescale 1ns / 1ps

module u8sr_ctl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  u8sr_pkg::dp_stat_t  stat,
    output u8sr_pkg::dp_cmd_t   ctl_cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_DISP   = 12'b000000000010,
        ST_ERR    = 12'b000000000100,
        ST_SC_RD  = 12'b000000001000,
        ST_SC_CHK = 12'b000000010000,
        ST_DECIDE = 12'b000000100000,
        ST_EM_RD  = 12'b000001000000,
        ST_EM_LD  = 12'b000010000000,
        ST_FL_RD  = 12'b000100000000,
        ST_FL_CHK = 12'b001000000000,
        ST_FL_EM  = 12'b010000000000,
        ST_FL_REP = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl_cmd    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl_cmd.take_item = 1'b1;
                    state_next        = ST_DISP;
                end
            end
            ST_DISP:
            begin
                priority if (stat.item_flush)
                begin
                    if (stat.empty)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctl_cmd.flush_init = 1'b1;
                        state_next         = ST_FL_RD;
                    end
                end
                else if (!stat.item_ok || stat.full)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    ctl_cmd.push_write = 1'b1;
                    if (stat.item_tend)
                    begin
                        ctl_cmd.scan_init = 1'b1;
                        state_next        = ST_SC_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (stat.out_free)
                begin
                    ctl_cmd.err_load = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SC_RD:
            begin
                if (stat.at_end)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    ctl_cmd.rd_issue = 1'b1;
                    state_next       = ST_SC_CHK;
                end
            end
            ST_SC_CHK:
            begin
                ctl_cmd.scan_step = 1'b1;
                state_next = (stat.dec_res == u8sr_pkg::DEC_BAD) ? ST_DECIDE : ST_SC_RD;
            end
            ST_DECIDE:
            begin
                if (stat.scan_accept)
                begin
                    ctl_cmd.emit_init = 1'b1;
                    state_next        = ST_EM_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EM_RD:
            begin
                if (stat.out_free)
                begin
                    ctl_cmd.rd_issue = 1'b1;
                    state_next       = ST_EM_LD;
                end
            end
            ST_EM_LD:
            begin
                ctl_cmd.emit_load = 1'b1;
                state_next        = stat.emit_last ? ST_IDLE : ST_EM_RD;
            end
            ST_FL_RD:
            begin
                if (stat.at_end)
                begin
                    state_next = ST_FL_REP;
                end
                else
                begin
                    ctl_cmd.rd_issue = 1'b1;
                    state_next       = ST_FL_CHK;
                end
            end
            ST_FL_CHK:
            begin
                ctl_cmd.flush_step = 1'b1;
                unique case (stat.dec_res)
                    u8sr_pkg::DEC_DONE: state_next = ST_FL_EM;
                    u8sr_pkg::DEC_MORE: state_next = ST_FL_RD;
                    default:            state_next = ST_FL_REP;
                endcase
            end
            ST_FL_EM:
            begin
                if (stat.out_free)
                begin
                    ctl_cmd.char_load = 1'b1;
                    priority if (stat.char_final)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (stat.char_byte_last)
                    begin
                        state_next = ST_FL_RD;
                    end
                    else
                    begin
                        state_next = ST_FL_EM;
                    end
                end
            end
            ST_FL_REP:
            begin
                if (stat.out_free)
                begin
                    ctl_cmd.rep_load = 1'b1;
                    state_next       = stat.rep_final ? ST_IDLE : ST_FL_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

>>> hdl/utf8_stream_reassembler.sv
// Top level of the UTF-8 stream reassembler: controller plus datapath.
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | cmd, symbol, token_end
//  out     | output    | out_valid / out_stall| out_byte, replacement, status, run_last
//
//  An unmapped or overflowing push waits in the error state for the result
//  register. A token end scans the held bytes one at a time through the one
//  read port of the hold RAM and its registered read, then emits the prefix.
//  A flush emits each held good character and a replacement for each bad byte.
//  rst_n clears the controller, the fill count, the read base and out_valid;
//  the hold RAM is not cleared and only entries below the fill count are read.
//  out_stall holds the result register; the sequencer waits until it is free.

module utf8_stream_reassembler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [u8sr_pkg::SYM_W-1:0]        symbol,
    input  logic                              token_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [u8sr_pkg::BYTE_W-1:0]       out_byte,
    output logic                              replacement,
    output logic [u8sr_pkg::STATUS_W-1:0]     status,
    output logic                              run_last
);

    // Command and status buses between the sequencer and the datapath
    u8sr_pkg::dp_cmd_t  dp_cmd;
    u8sr_pkg::dp_stat_t dp_stat;

    // Sequencer: takes one item at a time and steps it through the datapath
    u8sr_ctl u_ctl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .stat    (dp_stat),
        .ctl_cmd (dp_cmd)
    );

    // Datapath: hold RAM as a circular buffer, character decoder, result register
    u8sr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_cmd     (dp_cmd),
        .stat        (dp_stat),
        .in_cmd      (cmd),
        .in_symbol   (symbol),
        .in_token_end(token_end),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .replacement (replacement),
        .status      (status),
        .run_last    (run_last)
    );

endmodule
